// ----- sv/crc6fc_pkg.sv -----
// crc6fc_pkg: transaction types, codes, frame layout and the CRC6 table for the
// 40-bit command frame codec. No dependencies.
package crc6fc_pkg;

  localparam int FRAME_W   = 40;
  localparam int CRC_W     = 6;
  localparam int DEV_W     = 6;
  localparam int ADDR_W    = 6;
  localparam int PAYLOAD_W = 20;
  localparam int STATUS_W  = 2;

  localparam logic [CRC_W-1:0] INIT_XOR = 6'h38;
  localparam logic [6:0]       GEN_POLY = 7'h59;

  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEV_ERR = 2'd2;

  localparam logic [CRC_W-1:0] CRC_TABLE [64] = '{
    6'h00, 6'h19, 6'h32, 6'h2b, 6'h3d, 6'h24, 6'h0f, 6'h16,
    6'h23, 6'h3a, 6'h11, 6'h08, 6'h1e, 6'h07, 6'h2c, 6'h35,
    6'h1f, 6'h06, 6'h2d, 6'h34, 6'h22, 6'h3b, 6'h10, 6'h09,
    6'h3c, 6'h25, 6'h0e, 6'h17, 6'h01, 6'h18, 6'h33, 6'h2a,
    6'h3e, 6'h27, 6'h0c, 6'h15, 6'h03, 6'h1a, 6'h31, 6'h28,
    6'h1d, 6'h04, 6'h2f, 6'h36, 6'h20, 6'h39, 6'h12, 6'h0b,
    6'h21, 6'h38, 6'h13, 6'h0a, 6'h1c, 6'h05, 6'h2e, 6'h37,
    6'h02, 6'h1b, 6'h30, 6'h29, 6'h3f, 6'h26, 6'h0d, 6'h14
  };

  typedef struct packed {
    logic                 func;
    logic                 primary_bit;
    logic                 wr_bit;
    logic [DEV_W-1:0]     chip_id;
    logic [ADDR_W-1:0]    reg_address;
    logic [PAYLOAD_W-1:0] payload;
    logic [FRAME_W-1:0]   rx_frame;
    logic [DEV_W-1:0]     expected_device;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]   frame_out;
    logic [CRC_W-1:0]     crc_value;
    logic [STATUS_W-1:0]  status;
    logic [DEV_W-1:0]     chip_id_out;
    logic [PAYLOAD_W-1:0] payload_out;
  } out_item_t;

endpackage

// ----- sv/crc6fc_crc.sv -----
// crc6fc_crc: seeded CRC6 over bits 39..6 of a 40-bit frame; bits 5..0 ignored.
// Four bitwise polynomial steps, then five table steps. Uses crc6fc_pkg.
module crc6fc_crc (
  input  logic [crc6fc_pkg::FRAME_W-1:0] frame,
  output logic [crc6fc_pkg::CRC_W-1:0]   crc
);

  logic [crc6fc_pkg::FRAME_W-1:0] w;
  logic [crc6fc_pkg::CRC_W-1:0]   acc;

  always_comb begin
    w = {frame[crc6fc_pkg::FRAME_W-1:crc6fc_pkg::CRC_W] ^
         {crc6fc_pkg::INIT_XOR, 28'd0}, {crc6fc_pkg::CRC_W{1'b0}}};
    for (int k = 0; k < 4; k++) begin
      if (w[39-k]) begin
        w[39-k -: 7] = w[39-k -: 7] ^ crc6fc_pkg::GEN_POLY;
      end
    end
    acc = '0;
    // groups at 35..30 down to 11..6
    for (int g = 0; g < 5; g++) begin
      acc = crc6fc_pkg::CRC_TABLE[w[35-6*g -: 6] ^ acc];
    end
    crc = acc;
  end

endmodule

// ----- sv/crc6_frame_codec.sv -----
// crc6_frame_codec: builds or checks 40-bit CRC6-protected command frames.
// Depends on crc6fc_pkg and crc6fc_crc.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------
//   input   | in_valid  | in_stall  | in_data  (in_item_t)
//   result  | out_valid | out_stall | out_data (out_item_t)
//
// One transaction per cycle while not stalled; each passes the input register, then the result register.
// The CRC and compare sit between the two registers.
// Reset (rst_n low, synchronous) empties both registers.
// in_stall rises only when both registers are full and out_stall is high.
module crc6_frame_codec (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  crc6fc_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output crc6fc_pkg::out_item_t out_data
);

  logic                  s1_valid_r;
  crc6fc_pkg::in_item_t  s1_data_r;
  logic                  out_valid_r;
  crc6fc_pkg::out_item_t out_data_r;
  crc6fc_pkg::out_item_t out_data_nxt;

  logic                               out_ready;
  logic                               s1_ready;
  logic [crc6fc_pkg::FRAME_W-1:0]     frame_build;
  logic [crc6fc_pkg::FRAME_W-1:0]     frame_sel;
  logic [crc6fc_pkg::CRC_W-1:0]       crc;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign frame_build = {s1_data_r.primary_bit, s1_data_r.wr_bit, s1_data_r.chip_id,
                        s1_data_r.reg_address, s1_data_r.payload,
                        {crc6fc_pkg::CRC_W{1'b0}}};
  assign frame_sel = (s1_data_r.func == crc6fc_pkg::FUNC_CHECK) ? s1_data_r.rx_frame
                                                                : frame_build;

  crc6fc_crc u_crc (
    .frame (frame_sel),
    .crc   (crc)
  );

  always_comb begin
    out_data_nxt.crc_value = crc;
    out_data_nxt.status    = crc6fc_pkg::ST_OK;
    if (s1_data_r.func == crc6fc_pkg::FUNC_CHECK) begin
      out_data_nxt.frame_out = frame_sel;
      priority if (frame_sel[crc6fc_pkg::CRC_W-1:0] != crc) begin
        out_data_nxt.status = crc6fc_pkg::ST_CRC_ERR;
      end else if (s1_data_r.expected_device != '0 &&
                   s1_data_r.expected_device != frame_sel[37:32]) begin
        out_data_nxt.status = crc6fc_pkg::ST_DEV_ERR;
      end else begin
        out_data_nxt.status = crc6fc_pkg::ST_OK;
      end
    end else begin
      out_data_nxt.frame_out = {frame_build[39:6], crc};
    end
    out_data_nxt.chip_id_out = frame_sel[37:32];
    out_data_nxt.payload_out = frame_sel[25:6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ok_crc_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == crc6fc_pkg::ST_OK) |->
      (out_data_r.crc_value == out_data_r.frame_out[5:0]))
    else $error("ok status with CRC field differing from computed CRC");

  a_fields_follow_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.chip_id_out == out_data_r.frame_out[37:32] &&
                     out_data_r.payload_out == out_data_r.frame_out[25:6]))
    else $error("extracted fields do not match frame");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_ready) |=> out_valid_r)
    else $error("input register transaction lost on advance");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");
`endif

endmodule
